// ----- design/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types and constants of the media transport controller: payload
// structures of the item and result words, operation codes and key codes.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // Field widths
  localparam int unsigned OpW   = 2;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned AddrW = 32;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned RowW  = 2;
  localparam int unsigned RateW = 20;

  // Default depth of the track start table.
  localparam int unsigned TableEntriesDef = 8;

  // Block rate after reset: blocks per second of audio.
  localparam logic [RateW-1:0] RateReset = 20'd172;

  // Operation codes of an item word.
  typedef enum logic [OpW-1:0] {
    OP_KEY   = 2'd0,
    OP_POLL  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_START = 2'd3
  } mtc_op_e;

  // PS/2 scancodes.
  localparam logic [KeyW-1:0] KeyBreak = 8'hF0;
  localparam logic [KeyW-1:0] KeyNext  = 8'h31;
  localparam logic [KeyW-1:0] KeyPrev  = 8'h4D;
  localparam logic [KeyW-1:0] KeyFfwd  = 8'h2B;
  localparam logic [KeyW-1:0] KeyRew   = 8'h32;
  localparam logic [KeyW-1:0] KeyDown  = 8'h3B;
  localparam logic [KeyW-1:0] KeyUp    = 8'h42;
  localparam logic [KeyW-1:0] KeyEnter = 8'h5A;
  localparam logic [KeyW-1:0] KeySpace = 8'h29;

  // Item word.
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [KeyW-1:0]  scancode;
    logic [AddrW-1:0] block_position;
    logic [IdxW-1:0]  table_index;
    logic [AddrW-1:0] table_value;
  } mtc_item_t;

  // Result word.
  typedef struct packed {
    logic             seek_valid;
    logic [AddrW-1:0] seek_address;
    logic             play_on;
    logic [IdxW-1:0]  track_now;
    logic [IdxW-1:0]  cursor_track;
    logic [RowW-1:0]  cursor_row;
    logic [IdxW-1:0]  window_top;
  } mtc_result_t;

endpackage

// ----- design/mtc_in_if.sv -----
// ----------------------------------------------------------------------------
// mtc_in_if
// Valid/ready channel that carries item words into the controller.
// ----------------------------------------------------------------------------
interface mtc_in_if;
  import mtc_pkg::*;

  logic      valid;
  logic      ready;
  mtc_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- design/mtc_out_if.sv -----
// ----------------------------------------------------------------------------
// mtc_out_if
// Valid/ready channel that carries result words out of the controller.
// ----------------------------------------------------------------------------
interface mtc_out_if;
  import mtc_pkg::*;

  logic        valid;
  logic        ready;
  mtc_result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- design/media_transport_control_core.sv -----
// ----------------------------------------------------------------------------
// media_transport_control_core
// Transport controller of a block-based audio player: track table, keyboard
// transport keys, selection cursor and end-of-track advance.
// ----------------------------------------------------------------------------
// Usage:
//   Item words enter on item_i (valid/ready). Each one, whether a key byte,
//   a position poll, a table load or a start command, yields exactly one
//   result word on result_o, in order. The block rate register is written
//   through cfg_we_i/cfg_wdata_i; the user must write it only while no word
//   is in flight; the block does not enforce this. Throughput is one word per
//   cycle while result_o takes its words; an accepted word passes through
//   the read stage into the result register. The track start table sits in
//   a synchronous memory with two read ports (start and end of the target
//   track); the start and end of the current track are forwarded from the
//   read data to the next word, so the memory read does not hold up the
//   following word.
//   When result_o stalls, one word waits in the result register and one in
//   the read stage; item_i then drops ready until the result is taken.
//   Reset empties the pipeline, clears all table entries (per-entry nonzero
//   flags), the transport and cursor state, and sets the block rate to 172.
// ----------------------------------------------------------------------------
module media_transport_control_core #(
  parameter int unsigned TABLE_ENTRIES = mtc_pkg::TableEntriesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mtc_pkg::RateW-1:0] cfg_wdata_i,
  mtc_in_if.sink                   item_i,
  mtc_out_if.source                result_o
);
  import mtc_pkg::*;

  // Only entries reachable by the table index field are stored.
  localparam int unsigned MemDepth = (TABLE_ENTRIES < (2 ** IdxW)) ? TABLE_ENTRIES : (2 ** IdxW);
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam int unsigned CntW     = $clog2(MemDepth + 1);

  // Configuration and state registers
  logic [RateW-1:0] rate_q;
  logic [AddrW-1:0] tbl_mem [MemDepth];
  logic [MemDepth-1:0] nz_q, nz_d;
  logic [IdxW-1:0]  total_q, total_d;
  logic [IdxW-1:0]  cur_idx_q, cur_idx_d;
  logic [AddrW-1:0] cur_start_q, cur_end_q;
  logic             play_q, play_d;
  logic             skip_q, skip_d;
  logic [IdxW-1:0]  csr_idx_q, csr_idx_d;
  logic [RowW-1:0]  csr_line_q, csr_line_d;
  logic [IdxW-1:0]  win_q, win_d;

  // Read stage
  logic             s2_valid_q;
  logic             s2_go_q, s2_go_d;
  logic             s2_seek_q, s2_seek_d;
  logic [AddrW-1:0] s2_addr_q, s2_addr_d;
  logic [AddrW-1:0] rd0_q, rd1_q;
  logic             rd_ok0_q, rd_ok1_q;

  // Result register
  logic             out_valid_q;
  mtc_result_t      out_q;

  // Handshake
  logic      acc;
  logic      s2_move;
  mtc_item_t itm;

  assign itm      = item_i.payload;
  assign s2_move  = s2_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s2_valid_q || s2_move;
  assign acc      = item_i.valid && item_i.ready;

  // Bounds of the target track read in the read stage.
  logic [AddrW-1:0] s2_start, s2_end;
  assign s2_start = rd_ok0_q ? rd0_q : '0;
  assign s2_end   = rd_ok1_q ? rd1_q : '0;

  // Current track bounds with the pending seek forwarded.
  logic [AddrW-1:0] eff_start, eff_end;
  assign eff_start = (s2_valid_q && s2_go_q) ? s2_start : cur_start_q;
  assign eff_end   = (s2_valid_q && s2_go_q) ? s2_end   : cur_end_q;

  // Distance limits in blocks.
  logic [AddrW-1:0] two_c, five_c, dist_in, dist_left;
  assign two_c     = AddrW'(rate_q) << 1;
  assign five_c    = (AddrW'(rate_q) << 2) + AddrW'(rate_q);
  assign dist_in   = itm.block_position - eff_start;
  assign dist_left = eff_end - itm.block_position;

  // Decode of the item word.
  logic [IdxW:0]   tgt;
  logic [IdxW-1:0] t_sel;
  logic [IdxW:0]   t_next;
  logic            wr_en;
  logic [MemAw-1:0] wr_addr;
  logic [IdxW:0]   cur_next, cur_prev;

  assign cur_next = {1'b0, cur_idx_q} + 1'b1;
  assign cur_prev = (cur_idx_q == '0) ? '1 : ({1'b0, cur_idx_q} - 1'b1);

  always_comb begin
    play_d     = play_q;
    skip_d     = skip_q;
    csr_idx_d  = csr_idx_q;
    csr_line_d = csr_line_q;
    win_d      = win_q;
    s2_go_d    = 1'b0;
    s2_seek_d  = 1'b0;
    s2_addr_d  = '0;
    tgt        = '0;
    wr_en      = 1'b0;
    unique case (mtc_op_e'(itm.operation))
      OP_KEY: begin
        if (skip_q) begin
          skip_d = 1'b0;
        end else begin
          unique case (itm.scancode)
            KeyBreak: skip_d = 1'b1;
            KeyNext: begin
              tgt = cur_next;
              s2_go_d = 1'b1;
              play_d = 1'b1;
            end
            KeyPrev: begin
              tgt = (dist_in < two_c) ? cur_prev : {1'b0, cur_idx_q};
              s2_go_d = 1'b1;
              play_d = 1'b1;
            end
            KeyFfwd: begin
              if (dist_left < five_c) begin
                tgt = cur_next;
                s2_go_d = 1'b1;
              end else begin
                s2_seek_d = 1'b1;
                s2_addr_d = itm.block_position + five_c;
              end
              play_d = 1'b1;
            end
            KeyRew: begin
              if (dist_in < five_c) begin
                tgt = {1'b0, cur_idx_q};
                s2_go_d = 1'b1;
              end else begin
                s2_seek_d = 1'b1;
                s2_addr_d = itm.block_position - five_c;
              end
              play_d = 1'b1;
            end
            KeyDown: begin
              if (({1'b0, csr_idx_q} + 1'b1) < {1'b0, total_q}) begin
                if (csr_line_q == '1) begin
                  win_d = win_q + 1'b1;
                end else begin
                  csr_line_d = csr_line_q + 1'b1;
                end
                csr_idx_d = csr_idx_q + 1'b1;
              end
            end
            KeyUp: begin
              if (csr_idx_q != '0) begin
                if (csr_line_q == '0) begin
                  win_d = win_q - 1'b1;
                end else begin
                  csr_line_d = csr_line_q - 1'b1;
                end
                csr_idx_d = csr_idx_q - 1'b1;
              end
            end
            KeyEnter: begin
              tgt = {1'b0, csr_idx_q};
              s2_go_d = 1'b1;
              play_d = 1'b1;
            end
            KeySpace: play_d = !play_q;
            default: ;
          endcase
        end
      end
      OP_POLL: begin
        if (itm.block_position >= eff_end) begin
          tgt = cur_next;
          s2_go_d = 1'b1;
        end
      end
      OP_LOAD: begin
        wr_en = (32'(itm.table_index) < MemDepth);
      end
      OP_START: begin
        s2_go_d    = 1'b1;
        play_d     = 1'b1;
        csr_idx_d  = '0;
        csr_line_d = '0;
        win_d      = '0;
      end
      default: ;
    endcase
    if (s2_go_d) begin
      s2_seek_d = 1'b1;
    end
  end

  // Target track, wrapped to zero past the last one.
  assign t_sel     = (tgt >= {1'b0, total_q}) ? '0 : tgt[IdxW-1:0];
  assign t_next    = {1'b0, t_sel} + 1'b1;
  assign cur_idx_d = s2_go_d ? t_sel : cur_idx_q;
  assign wr_addr   = itm.table_index[MemAw-1:0];

  // Nonzero flags and track count after a table load.
  logic [CntW-1:0] cnt;
  always_comb begin
    nz_d = nz_q;
    cnt  = '0;
    if (wr_en) begin
      nz_d[wr_addr] = (itm.table_value != '0);
    end
    for (int i = 0; i < MemDepth; i++) begin
      cnt = cnt + CntW'(nz_d[i]);
    end
    total_d = (cnt == '0) ? '0 : IdxW'(cnt - 1'b1);
  end

  // Read addresses for the start and end of the target track.
  logic            rd_in0, rd_in1;
  logic [MemAw-1:0] rd_a0, rd_a1;
  assign rd_in0 = (32'(t_sel) < MemDepth);
  assign rd_in1 = (32'(t_next) < MemDepth);
  assign rd_a0  = t_sel[MemAw-1:0];
  assign rd_a1  = t_next[MemAw-1:0];

  // Track table memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (wr_en) begin
        tbl_mem[wr_addr] <= itm.table_value;
      end
      rd0_q <= tbl_mem[rd_a0];
      rd1_q <= tbl_mem[rd_a1];
    end
  end

  // Read stage payload.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s2_go_q   <= s2_go_d;
      s2_seek_q <= s2_seek_d;
      s2_addr_q <= s2_addr_d;
    end
  end

  // Entry validity captured with the read, and all control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RateReset;
      nz_q        <= '0;
      total_q     <= '0;
      cur_idx_q   <= '0;
      cur_start_q <= '0;
      cur_end_q   <= '0;
      play_q      <= 1'b0;
      skip_q      <= 1'b0;
      csr_idx_q   <= '0;
      csr_line_q  <= '0;
      win_q       <= '0;
      rd_ok0_q    <= 1'b0;
      rd_ok1_q    <= 1'b0;
      s2_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (acc) begin
        nz_q       <= nz_d;
        total_q    <= total_d;
        cur_idx_q  <= cur_idx_d;
        play_q     <= play_d;
        skip_q     <= skip_d;
        csr_idx_q  <= csr_idx_d;
        csr_line_q <= csr_line_d;
        win_q      <= win_d;
        rd_ok0_q   <= rd_in0 && nz_q[rd_a0];
        rd_ok1_q   <= rd_in1 && nz_q[rd_a1];
      end
      if (s2_valid_q && s2_go_q) begin
        cur_start_q <= s2_start;
        cur_end_q   <= s2_end;
      end
      if (acc) begin
        s2_valid_q <= 1'b1;
      end else if (s2_move) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Result register; state registers still hold the word's outcome here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_move) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      out_q.seek_valid   <= s2_seek_q;
      out_q.seek_address <= s2_go_q ? s2_start : s2_addr_q;
      out_q.play_on      <= play_q;
      out_q.track_now    <= cur_idx_q;
      out_q.cursor_track <= csr_idx_q;
      out_q.cursor_row   <= csr_line_q;
      out_q.window_top   <= win_q;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  // Assertions
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_valid_q && !result_o.ready |-> !item_i.ready)
    else $error("Item accepted while both pipeline stages are stalled.");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> s2_valid_q)
    else $error("Accepted word did not enter the read stage.");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) < MemDepth)
    else $error("Track total exceeds the table depth.");

  a_cursor_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IdxW'(win_q + IdxW'(csr_line_q)) == csr_idx_q)
    else $error("Cursor row and window top disagree with the cursor track.");

endmodule

// ----- sim/tb_media_transport_control_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_media_transport_control_core
// Self-checking bench for the transport controller. Item words go in through
// the valid/ready input channel. A behavioral copy of the controller state
// (track table, current track bounds, play flag, break-code skip and
// selection window) works out the status word that each accepted item must
// produce. Directed tests cover the empty table, table loads and every key.
// Random traffic under several block rates and idle/stall mixes follows.
// ----------------------------------------------------------------------------
module tb_media_transport_control_core;
  import mtc_pkg::*;

  localparam int unsigned TableDepth = TableEntriesDef;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [RateW-1:0]     cfg_wdata_i;

  mtc_in_if  item_if ();
  mtc_out_if result_if ();

  media_transport_control_core #(
    .TABLE_ENTRIES(TableDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .result_o    (result_if)
  );

  // Expected controller state, updated as each item word is accepted.
  logic [AddrW-1:0] start_addr [TableDepth] = '{default: '0};
  int unsigned      num_tracks = 0;
  int unsigned      play_track = 0;
  logic [AddrW-1:0] play_start = '0;
  logic [AddrW-1:0] play_end   = '0;
  logic             play_en    = 1'b0;
  logic             drop_next  = 1'b0;
  int unsigned      sel_track  = 0;
  int unsigned      sel_row    = 0;
  int unsigned      win_top    = 0;
  logic [RateW-1:0] rate       = RateReset;

  mtc_result_t pending_status [$];
  int          mismatches = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;

  // 50 MHz clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // Moves to track t, wrapping to track 0 past the last one, and reads its start.
  function automatic void seek_track(int unsigned t, inout mtc_result_t r);
    if (t >= num_tracks) begin
      t = 0;
    end
    play_track = t;
    play_start = (t < TableDepth) ? start_addr[t] : '0;
    play_end   = (t + 1 < TableDepth) ? start_addr[t + 1] : '0;
    r.seek_valid   = 1'b1;
    r.seek_address = play_start;
  endfunction

  // Works out the status word of one accepted item and queues it.
  function automatic void predict_transport(mtc_item_t w);
    mtc_result_t      r;
    logic [AddrW-1:0] two;
    logic [AddrW-1:0] five;
    int unsigned      n;
    r    = '0;
    two  = 32'(rate) * 32'd2;
    five = 32'(rate) * 32'd5;
    case (w.operation)
      OP_KEY: begin
        if (drop_next) begin
          // The byte after a break code is the released key.
          drop_next = 1'b0;
        end else begin
          case (w.scancode)
            KeyBreak: drop_next = 1'b1;
            KeyNext: begin
              seek_track(play_track + 1, r);
              play_en = 1'b1;
            end
            KeyPrev: begin
              if (w.block_position - play_start < two) begin
                seek_track(play_track - 1, r);
              end else begin
                seek_track(play_track, r);
              end
              play_en = 1'b1;
            end
            KeyFfwd: begin
              if (play_end - w.block_position < five) begin
                seek_track(play_track + 1, r);
              end else begin
                r.seek_valid   = 1'b1;
                r.seek_address = w.block_position + five;
              end
              play_en = 1'b1;
            end
            KeyRew: begin
              if (w.block_position - play_start < five) begin
                seek_track(play_track, r);
              end else begin
                r.seek_valid   = 1'b1;
                r.seek_address = w.block_position - five;
              end
              play_en = 1'b1;
            end
            KeyDown: begin
              if (sel_track + 1 < num_tracks) begin
                if (sel_row == 3) begin
                  win_top++;
                end else begin
                  sel_row++;
                end
                sel_track++;
              end
            end
            KeyUp: begin
              if (sel_track != 0) begin
                if (sel_row == 0) begin
                  win_top--;
                end else begin
                  sel_row--;
                end
                sel_track--;
              end
            end
            KeyEnter: begin
              seek_track(sel_track, r);
              play_en = 1'b1;
            end
            KeySpace: play_en = !play_en;
            default: ;
          endcase
        end
      end
      OP_POLL: begin
        if (w.block_position >= play_end) begin
          seek_track(play_track + 1, r);
        end
      end
      OP_LOAD: begin
        if (w.table_index < TableDepth) begin
          start_addr[w.table_index] = w.table_value;
          n = 0;
          for (int i = 0; i < TableDepth; i++) begin
            if (start_addr[i] != '0) begin
              n++;
            end
          end
          num_tracks = (n > 0) ? n - 1 : 0;
        end
      end
      default: begin
        seek_track(0, r);
        sel_track = 0;
        sel_row   = 0;
        win_top   = 0;
        play_en   = 1'b1;
      end
    endcase
    r.play_on      = play_en;
    r.track_now    = 3'(play_track);
    r.cursor_track = 3'(sel_track);
    r.cursor_row   = 2'(sel_row);
    r.window_top   = 3'(win_top);
    pending_status.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [AddrW-1:0] want,
                                      logic [AddrW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver side: random stall at the rate of the current phase.
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Each status word taken is compared with the oldest expected one.
  always @(posedge clk_i) begin : check_status
    mtc_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_status.size() == 0) begin
        $error("status word arrived with none expected");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("seek_valid", want.seek_valid, result_if.payload.seek_valid);
        check_field("seek_address", want.seek_address, result_if.payload.seek_address);
        check_field("play_on", want.play_on, result_if.payload.play_on);
        check_field("track_now", want.track_now, result_if.payload.track_now);
        check_field("cursor_track", want.cursor_track, result_if.payload.cursor_track);
        check_field("cursor_row", want.cursor_row, result_if.payload.cursor_row);
        check_field("window_top", want.window_top, result_if.payload.window_top);
      end
    end
  end

  // Sends one item word after a random idle gap and predicts its status.
  task automatic send_word(input mtc_item_t w);
    while ($urandom_range(99) < idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.payload <= w;
    do @(posedge clk_i); while (!item_if.ready);
    predict_transport(w);
  endtask

  task automatic send_key(input logic [KeyW-1:0] code, input logic [AddrW-1:0] pos);
    mtc_item_t w;
    w = {OP_KEY, code, pos, 3'($urandom), 32'($urandom)};
    send_word(w);
  endtask

  task automatic send_poll(input logic [AddrW-1:0] pos);
    mtc_item_t w;
    w = {OP_POLL, 8'($urandom), pos, 3'($urandom), 32'($urandom)};
    send_word(w);
  endtask

  task automatic send_load(input logic [IdxW-1:0] idx, input logic [AddrW-1:0] val);
    mtc_item_t w;
    w = {OP_LOAD, 8'($urandom), 32'($urandom), idx, val};
    send_word(w);
  endtask

  task automatic send_start();
    mtc_item_t w;
    w = {OP_START, 8'($urandom), 32'($urandom), 3'($urandom), 32'($urandom)};
    send_word(w);
  endtask

  // Stops sending and waits until every expected status word has arrived.
  task automatic drain_results();
    item_if.valid <= 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // The rate register is only written while the controller is idle.
  task automatic write_rate(input logic [RateW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate = value;
  endtask

  // A position near the current track bounds, on either side of the
  // two- and five-second thresholds, or anywhere at all.
  function automatic logic [AddrW-1:0] pick_position();
    logic [AddrW-1:0] two;
    logic [AddrW-1:0] five;
    logic [AddrW-1:0] off;
    two  = 32'(rate) * 32'd2;
    five = 32'(rate) * 32'd5;
    case ($urandom_range(9))
      0: off = '0;
      1: off = two - 1;
      2: off = two;
      3: off = five - 1;
      4: off = five;
      5: off = five + 1;
      default: off = $urandom_range(0, 32'(rate) * 8 + 8);
    endcase
    case ($urandom_range(4))
      0, 1: return play_start + off;
      2, 3: return play_end - off;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(7))
      0: return KeyNext;
      1: return KeyPrev;
      2: return KeyFfwd;
      3: return KeyRew;
      4: return KeyDown;
      5: return KeyUp;
      6: return KeyEnter;
      default: return KeySpace;
    endcase
  endfunction

  // Mostly well-formed traffic: increasing track starts, keys with positions
  // close to the decision thresholds, and some unused entries and noise.
  task automatic send_random_word();
    int unsigned      pick;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] span;
    logic [AddrW-1:0] val;
    pick = $urandom_range(99);
    span = 32'(rate) * 32'd20 + 32'd64;
    if (pick < 8) begin
      idx = 3'($urandom_range(7));
      case ($urandom_range(9))
        0, 1: val = '0;
        2: val = $urandom;
        default: val = (32'(idx) + 1) * span + $urandom_range(0, span / 2);
      endcase
      send_load(idx, val);
    end else if (pick < 11) begin
      send_start();
    end else if (pick < 31) begin
      send_poll(pick_position());
    end else if (pick < 36) begin
      send_key(KeyBreak, pick_position());
      send_key(pick_key(), pick_position());
    end else if (pick < 42) begin
      send_key(8'($urandom_range(255)), $urandom);
    end else begin
      send_key(pick_key(), pick_position());
    end
  endtask

  // With no tracks loaded every seek falls back to track 0 at address 0.
  task automatic test_empty_table();
    send_poll(32'hFFFF_FFFF);
    send_key(KeyNext, 32'h0000_0000);
  endtask

  // Seven tracks; the last entry only marks the end of the last track.
  task automatic test_table_load();
    for (int i = 0; i < 7; i++) begin
      send_load(3'(i), 32'h0000_1000 + 32'(i) * 32'h0010_0000);
    end
    send_load(3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_transport_keys();
    send_start();
    send_key(KeyNext, 32'h0000_0000);
    // Early in the track: previous track, then a wrap from track zero.
    send_key(KeyPrev, play_start + 32'(rate) * 2 - 1);
    send_key(KeyPrev, play_start + 32'd5);
    // Past two seconds: restart the track.
    send_key(KeyPrev, play_start + 32'(rate) * 2);
    // Exactly five seconds left jumps ahead; one block less moves on.
    send_key(KeyFfwd, play_end - 32'(rate) * 5);
    send_key(KeyFfwd, play_end - 32'(rate) * 5 + 1);
    send_key(KeyRew, play_start + 32'(rate) * 5 - 1);
    send_key(KeyRew, 32'hFFFF_FFFF);
    send_key(KeySpace, 32'h0000_0000);
    // The break code swallows the key after it.
    send_key(KeyBreak, 32'h0000_0000);
    send_key(KeyNext, 32'h0000_0000);
    send_key(8'hFF, 32'h0000_0000);
    send_poll(play_end - 1);
    send_poll(play_end);
  endtask

  // Four moves down scroll the window once; four moves up scroll it back.
  task automatic test_cursor();
    repeat (4) send_key(KeyDown, 32'h0000_0000);
    send_key(KeyEnter, 32'h0000_0000);
    repeat (4) send_key(KeyUp, 32'h0000_0000);
  endtask

  // One phase of random traffic; halfway through the sender waits until
  // every status word is back.
  task automatic test_random_traffic(input logic [RateW-1:0] new_rate,
                                     input int idle, input int stall,
                                     input int count);
    write_rate(new_rate);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        drain_results();
      end
      send_random_word();
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    item_if.valid     = 1'b0;
    item_if.payload   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_table_load();
    test_transport_keys();
    test_cursor();
    test_random_traffic(20'd172, 0, 0, 140);
    test_random_traffic(20'd1, 49, 0, 140);
    test_random_traffic(20'hF_FFFF, 0, 49, 140);
    test_random_traffic(20'd0, 25, 25, 100);
    test_random_traffic(20'($urandom_range(1, 4000)), 25, 25, 140);
    test_random_traffic(20'd3, 0, 0, 140);
    drain_results();

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
